// ===== src/vgmcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// vgmcsp_pkg
// Shared types and constants of the VGM command stream parser.
// ----------------------------------------------------------------------------
package vgmcsp_pkg;

  // Default width of the byte position counters.
  localparam int PositionBits = 32;

  // Header layout.
  localparam logic [31:0] HdrOffsetFirst = 32'h34;
  localparam logic [31:0] HdrOffsetLast  = 32'h37;
  localparam logic [31:0] DefaultStart   = 32'h40;
  localparam logic [31:0] MinStart       = 32'h38;

  // Command codes.
  localparam logic [7:0] CmdPortWrite = 8'hbc;
  localparam logic [7:0] CmdRamWrite  = 8'hc6;
  localparam logic [7:0] CmdEndData   = 8'h66;
  localparam logic [7:0] CmdDataBlock = 8'h67;
  localparam logic [7:0] CmdWait      = 8'h61;
  localparam logic [7:0] CmdChipLo    = 8'h51;
  localparam logic [7:0] CmdChipHi    = 8'h5f;
  localparam logic [7:0] CmdStereo    = 8'h4f;
  localparam logic [7:0] CmdPsg       = 8'h50;

  typedef enum logic [2:0] {
    EvPort      = 3'd0,
    EvRam       = 3'd1,
    EvEnd       = 3'd2,
    EvTruncPort = 3'd3,
    EvTruncRam  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] position;
    logic [15:0] address;
    logic [7:0]  value;
  } ev_data_t;

  typedef struct packed {
    logic     valid;
    ev_data_t data;
  } evt_t;

endpackage

// ===== src/vgmcsp_core.sv =====
// ----------------------------------------------------------------------------
// vgmcsp_core
// Per-byte parser state: header offset capture, command length tracking and
// event generation. One byte is consumed in every accepted cycle.
// ----------------------------------------------------------------------------
module vgmcsp_core #(
  parameter int POSITION_BITS = vgmcsp_pkg::PositionBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_i,
  input  logic                last_i,
  output vgmcsp_pkg::evt_t    evt_o
);

  typedef enum logic [2:0] {
    PhHeader,
    PhSeek,
    PhCommand,
    PhArgs,
    PhSkip,
    PhDone
  } phase_e;

  localparam logic [63:0] PosMaskWide = (64'd1 << POSITION_BITS) - 64'd1;
  localparam logic [31:0] PosMask     = PosMaskWide[31:0];

  phase_e                     phase_q, phase_d;
  logic [POSITION_BITS-1:0]   pos_q, pos_d;
  logic [31:0]                start_q, start_d;
  logic [7:0]                 cmd_q, cmd_d;
  logic [2:0]                 idx_q, idx_d;
  logic [31:0]                skip_q, skip_d;
  logic [15:0]                addr_q, addr_d;
  logic [POSITION_BITS-1:0]   cmd_pos_q, cmd_pos_d;

  logic                       do_start;
  logic [31:0]                hdr_value;
  logic [31:0]                hdr_sum;
  logic [31:0]                hdr_start;
  logic [1:0]                 size_lane;
  vgmcsp_pkg::evt_t           evt;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    start_d   = start_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    skip_d    = skip_q;
    addr_d    = addr_q;
    cmd_pos_d = cmd_pos_q;
    evt       = '0;
    do_start  = 1'b0;
    hdr_value = {data_i, start_q[23:0]};
    hdr_sum   = hdr_value + vgmcsp_pkg::HdrOffsetFirst;
    size_lane = 2'(idx_q - 3'd3);

    // A zero offset selects the default start; tiny offsets are clamped.
    if (hdr_value == '0) begin
      hdr_start = vgmcsp_pkg::DefaultStart;
    end else if (hdr_sum < vgmcsp_pkg::MinStart) begin
      hdr_start = vgmcsp_pkg::MinStart;
    end else begin
      hdr_start = hdr_sum;
    end

    if (accept_i) begin
      unique case (phase_q)
        PhHeader: begin
          if (pos_q >= POSITION_BITS'(vgmcsp_pkg::HdrOffsetFirst) &&
              pos_q <= POSITION_BITS'(vgmcsp_pkg::HdrOffsetLast)) begin
            if (pos_q == POSITION_BITS'(vgmcsp_pkg::HdrOffsetFirst)) begin
              start_d = {24'd0, data_i};
            end else begin
              start_d[{pos_q[1:0], 3'b000} +: 8] = data_i;
            end
            if (pos_q == POSITION_BITS'(vgmcsp_pkg::HdrOffsetLast)) begin
              start_d = hdr_start & PosMask;
              phase_d = PhSeek;
            end
          end
        end
        PhSeek: begin
          do_start = (pos_q == start_q[POSITION_BITS-1:0]);
        end
        PhCommand: begin
          do_start = 1'b1;
        end
        PhArgs: begin
          idx_d = idx_q + 3'd1;
          if (cmd_q == vgmcsp_pkg::CmdPortWrite) begin
            if (idx_q == 3'd1) begin
              addr_d = {8'd0, data_i};
            end else begin
              phase_d             = PhCommand;
              evt.valid           = 1'b1;
              evt.data.kind       = vgmcsp_pkg::EvPort;
              evt.data.position   = 32'(cmd_pos_q);
              evt.data.address    = addr_q;
              evt.data.value      = data_i;
            end
          end else if (cmd_q == vgmcsp_pkg::CmdRamWrite) begin
            if (idx_q == 3'd1) begin
              addr_d = {8'd0, data_i};
            end else if (idx_q == 3'd2) begin
              addr_d = {data_i, addr_q[7:0]};
            end else begin
              phase_d             = PhCommand;
              evt.valid           = 1'b1;
              evt.data.kind       = vgmcsp_pkg::EvRam;
              evt.data.position   = 32'(cmd_pos_q);
              evt.data.address    = addr_q;
              evt.data.value      = data_i;
            end
          end else begin
            // Data block: bytes three to six carry the block size, low first.
            if (idx_q >= 3'd3 && idx_q <= 3'd6) begin
              skip_d = skip_q | (32'(data_i) << {size_lane, 3'b000});
            end
            if (idx_q >= 3'd6) begin
              phase_d = (skip_d == '0) ? PhCommand : PhSkip;
            end
          end
        end
        PhSkip: begin
          skip_d = skip_q - 32'd1;
          if (skip_d == '0) begin
            phase_d = PhCommand;
          end
        end
        PhDone: begin
        end
        default: begin
        end
      endcase

      if (do_start) begin
        cmd_pos_d = pos_q;
        cmd_d     = data_i;
        idx_d     = 3'd1;
        unique case (data_i) inside
          vgmcsp_pkg::CmdEndData: begin
            phase_d           = PhDone;
            evt.valid         = 1'b1;
            evt.data.kind     = vgmcsp_pkg::EvEnd;
            evt.data.position = 32'(pos_q);
          end
          vgmcsp_pkg::CmdPortWrite, vgmcsp_pkg::CmdRamWrite,
          vgmcsp_pkg::CmdDataBlock: begin
            phase_d = PhArgs;
            skip_d  = '0;
            addr_d  = '0;
          end
          vgmcsp_pkg::CmdWait, [vgmcsp_pkg::CmdChipLo:vgmcsp_pkg::CmdChipHi]: begin
            phase_d = PhSkip;
            skip_d  = 32'd2;
          end
          vgmcsp_pkg::CmdStereo, vgmcsp_pkg::CmdPsg: begin
            phase_d = PhSkip;
            skip_d  = 32'd1;
          end
          default: begin
            phase_d = PhCommand;
          end
        endcase
      end

      pos_d = pos_q + POSITION_BITS'(1);

      if (last_i) begin
        // A port or RAM write still collecting arguments is cut off here.
        if (!evt.valid && phase_d == PhArgs) begin
          if (cmd_d == vgmcsp_pkg::CmdPortWrite) begin
            evt.valid         = 1'b1;
            evt.data.kind     = vgmcsp_pkg::EvTruncPort;
            evt.data.position = 32'(cmd_pos_d);
          end else if (cmd_d == vgmcsp_pkg::CmdRamWrite) begin
            evt.valid         = 1'b1;
            evt.data.kind     = vgmcsp_pkg::EvTruncRam;
            evt.data.position = 32'(cmd_pos_d);
          end
        end
        phase_d   = PhHeader;
        pos_d     = '0;
        start_d   = vgmcsp_pkg::DefaultStart;
        cmd_d     = '0;
        idx_d     = '0;
        skip_d    = '0;
        addr_d    = '0;
        cmd_pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      pos_q     <= '0;
      start_q   <= vgmcsp_pkg::DefaultStart;
      cmd_q     <= '0;
      idx_q     <= '0;
      skip_q    <= '0;
      addr_q    <= '0;
      cmd_pos_q <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      cmd_q     <= cmd_d;
      idx_q     <= idx_d;
      skip_q    <= skip_d;
      addr_q    <= addr_d;
      cmd_pos_q <= cmd_pos_d;
    end
  end

  assign evt_o = evt;

`ifndef ASSERT_OFF
  a_last_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> pos_q == '0 && phase_q == PhHeader)
    else $error("position not cleared after final byte");

  a_event_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt.valid |-> accept_i)
    else $error("event raised without an accepted byte");

  a_end_enters_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !last_i && evt.valid && evt.data.kind == vgmcsp_pkg::EvEnd
    |=> phase_q == PhDone)
    else $error("end of data did not stop parsing");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSkip |-> skip_q != '0)
    else $error("skip phase with empty count");
`endif

endmodule

// ===== src/vgmcsp_skid.sv =====
// ----------------------------------------------------------------------------
// vgmcsp_skid
// Two-entry output buffer for parser events. The parser keeps running while
// one event waits downstream; it stalls only when both entries are full.
// ----------------------------------------------------------------------------
module vgmcsp_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  vgmcsp_pkg::ev_data_t push_data_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output vgmcsp_pkg::ev_data_t out_data_o,
  input  logic                 out_ready_i
);

  logic                 main_valid_q, main_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  vgmcsp_pkg::ev_data_t main_q, main_d;
  vgmcsp_pkg::ev_data_t skid_q, skid_d;
  logic                 pop;

  assign pop = main_valid_q && out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

`ifndef ASSERT_OFF
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("overflow entry filled while head is empty");

  a_fill_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_valid_q && !pop && !skid_valid_q && push_i |=> skid_valid_q)
    else $error("stalled event was not parked");

  a_skid_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && pop |=> main_valid_q && !skid_valid_q)
    else $error("overflow entry did not move to head");
`endif

endmodule

// ===== src/vgm_command_stream_parser.sv =====
// ----------------------------------------------------------------------------
// vgm_command_stream_parser
// Walks a VGM file byte by byte and reports port writes, RAM writes, end of
// data and writes cut short by the end of the file.
// ----------------------------------------------------------------------------
// The parser takes one file byte per clock on the slave stream, with tlast on
// the final byte, and reports at most one event per byte on the master stream
// from a register of the output buffer. The event kind travels in tuser.
// A two-entry output buffer lets bytes keep flowing while an event waits, so
// the input only stalls when two events are pending downstream. The final
// byte of a file returns the parser to its header state, ready for the next.
// ----------------------------------------------------------------------------
module vgm_command_stream_parser #(
  parameter int POSITION_BITS = vgmcsp_pkg::PositionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] command_position,
                                      // [47:32] port_or_address,
                                      // [55:48] write_value
  output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);

  logic                 accept;
  vgmcsp_pkg::evt_t     evt;
  vgmcsp_pkg::ev_data_t out_data;

  assign accept = s_axis_tvalid && s_axis_tready;

  vgmcsp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .data_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .evt_o   (evt)
  );

  vgmcsp_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (evt.valid),
    .push_data_i(evt.data),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (out_data),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {out_data.value, out_data.address, out_data.position};
  assign m_axis_tuser = out_data.kind;

endmodule
